// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the subsampled integral image RTL.
// Every macro samples on clk and is disabled while rst_n is low.
// Synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SSII_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SSII_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SSII_ASSERT(lbl, prop, msg)

`define SSII_NEVER(lbl, expr, msg)

`endif

`endif

// ----- rtl/ssii_pkg.sv -----
// Package for the subsampled integral image unit: widths, defaults,
// register map, shared structs and the register clamp function. No dependencies.
`timescale 1ns / 1ps

package ssii_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_W    = 11;
    localparam int ACC_W    = 36;
    localparam int GRID_W   = 10;
    localparam int PH_W     = 10;
    localparam int RATE_MAX = 1024;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
    localparam logic [CFG_W-1:0] RST_SUBSAMPLE_RATE = 11'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam int OUT_TDATA_W = ACC_W + 2 * GRID_W;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_SUBSAMPLE_RATE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic              end_row;
        logic              row_zero;
        logic [GRID_W-1:0] grid_col;
        logic [GRID_W-1:0] grid_row;
    } ctrl_info_t;

    typedef struct packed {
        logic              last;
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
        logic [ACC_W-1:0]  sum;
    } out_word_t;

    function automatic logic [CFG_W-1:0] clamp_cfg(logic [CFG_W-1:0] v, int unsigned hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (32'(v) > hi)
        begin
            r = CFG_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/ssii_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the entry being written returns the old contents. No dependencies.
`timescale 1ns / 1ps

module ssii_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ----- rtl/ssii_div.sv -----
// Two-lane restoring divider that turns the clamped image size into grid size.
// Depends on ssii_pkg; one quotient bit per cycle, reruns after reset and on start.
`timescale 1ns / 1ps

module ssii_div import ssii_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CFG_W-1:0] dividend_a,
    input  logic [CFG_W-1:0] dividend_b,
    input  logic [CFG_W-1:0] divisor,
    output logic             busy,
    output logic [CFG_W-1:0] quot_a,
    output logic [CFG_W-1:0] quot_b
);

    localparam int CNT_W = $clog2(CFG_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [CFG_W-1:0] quot_a_reg, quot_a_next, quot_b_reg, quot_b_next;
    logic [CNT_W-1:0] bit_idx;
    logic [CFG_W:0]   trial_a, trial_b;
    logic             take_a, take_b;

    always_comb
    begin
        bit_idx = CNT_W'(CFG_W - 1) - cnt_reg;
        trial_a = {rem_a_reg, dividend_a[bit_idx]};
        trial_b = {rem_b_reg, dividend_b[bit_idx]};
        take_a  = trial_a >= {1'b0, divisor};
        take_b  = trial_b >= {1'b0, divisor};

        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rem_a_next  = rem_a_reg;
        rem_b_next  = rem_b_reg;
        quot_a_next = quot_a_reg;
        quot_b_next = quot_b_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_a_next = '0;
            rem_b_next = '0;
        end
        else if (busy_reg)
        begin
            rem_a_next  = take_a ? CFG_W'(trial_a - {1'b0, divisor}) : CFG_W'(trial_a);
            rem_b_next  = take_b ? CFG_W'(trial_b - {1'b0, divisor}) : CFG_W'(trial_b);
            quot_a_next = {quot_a_reg[CFG_W-2:0], take_a};
            quot_b_next = {quot_b_reg[CFG_W-2:0], take_b};
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CFG_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_a_reg <= quot_a_next;
        quot_b_reg <= quot_b_next;
    end

    assign busy   = busy_reg;
    assign quot_a = quot_a_reg;
    assign quot_b = quot_b_reg;

endmodule

// ----- rtl/ssii_ctrl.sv -----
// Raster position, subsample phase and grid counters for the integral image.
// Depends on ssii_pkg; describes the word being accepted and advances on step.
`timescale 1ns / 1ps

module ssii_ctrl import ssii_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [CFG_W-1:0]             cfg_width,
    input  logic [CFG_W-1:0]             cfg_height,
    input  logic [CFG_W-1:0]             cfg_rate,
    input  logic [CFG_W-1:0]             grid_width,
    input  logic [CFG_W-1:0]             grid_height,
    output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
    output ctrl_info_t                   info
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int MW    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int XW    = ((MW > CFG_W) ? MW : CFG_W) + 1;

    logic [COL_W-1:0] pcol_reg, pcol_next, ocol_reg, ocol_next;
    logic [ROW_W-1:0] prow_reg, prow_next, orow_reg, orow_next;
    logic [PH_W-1:0]  cph_reg, cph_next, rph_reg, rph_next;
    logic [PH_W-1:0]  cph, rph, cph_wrap, rph_wrap;
    logic [XW-1:0]    cph_inc, rph_inc;
    logic             col_end, img_end;

    always_comb
    begin
        cph      = (XW'(cph_reg) >= XW'(cfg_rate)) ? '0 : cph_reg;
        rph      = (XW'(rph_reg) >= XW'(cfg_rate)) ? '0 : rph_reg;
        cph_inc  = XW'(cph) + XW'(1);
        rph_inc  = XW'(rph) + XW'(1);
        cph_wrap = (cph_inc >= XW'(cfg_rate)) ? '0 : PH_W'(cph_inc);
        rph_wrap = (rph_inc >= XW'(cfg_rate)) ? '0 : PH_W'(rph_inc);
        col_end  = (XW'(pcol_reg) + XW'(1)) >= XW'(cfg_width);
        img_end  = col_end && ((XW'(prow_reg) + XW'(1)) >= XW'(cfg_height));

        info.emit     = (cph == '0) && (rph == '0)
                        && (XW'(ocol_reg) < XW'(grid_width))
                        && (XW'(orow_reg) < XW'(grid_height));
        info.last     = ((XW'(ocol_reg) + XW'(1)) == XW'(grid_width))
                        && ((XW'(orow_reg) + XW'(1)) == XW'(grid_height));
        info.end_row  = col_end;
        info.row_zero = (prow_reg == '0);
        info.grid_col = GRID_W'(ocol_reg);
        info.grid_row = GRID_W'(orow_reg);
        col_addr      = pcol_reg;
    end

    always_comb
    begin
        pcol_next = pcol_reg;
        ocol_next = ocol_reg;
        cph_next  = cph;
        prow_next = prow_reg;
        orow_next = orow_reg;
        rph_next  = rph;

        if (!col_end)
        begin
            ocol_next = (cph == '0) ? ocol_reg + COL_W'(1) : ocol_reg;
            cph_next  = cph_wrap;
            pcol_next = pcol_reg + COL_W'(1);
        end
        else
        begin
            pcol_next = '0;
            ocol_next = '0;
            cph_next  = '0;
            if (img_end)
            begin
                prow_next = '0;
                orow_next = '0;
                rph_next  = '0;
            end
            else
            begin
                orow_next = (rph == '0) ? orow_reg + ROW_W'(1) : orow_reg;
                rph_next  = rph_wrap;
                prow_next = prow_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            ocol_reg <= '0;
            cph_reg  <= '0;
            prow_reg <= '0;
            orow_reg <= '0;
            rph_reg  <= '0;
        end
        else if (step)
        begin
            pcol_reg <= pcol_next;
            ocol_reg <= ocol_next;
            cph_reg  <= cph_next;
            prow_reg <= prow_next;
            orow_reg <= orow_next;
            rph_reg  <= rph_next;
        end
    end

endmodule

// ----- rtl/subsampled_integral_image_unit.sv -----
// Subsampled integral image unit. Flow samples enter on the s_ stream in raster
// order, one word each; grid points of the integral image leave on the m_ stream
// as {grid_row, grid_column, integral_sum} with m_tlast on the last point of
// the image. Samples off the grid produce no output word.
// Image width, image height and subsample rate are written over the APB port.
// Throughput is one sample per cycle while s_tready is high. An accepted sample
// reads the row-above store as it is registered into stage s1, is summed there,
// then written back to the store and pushed into the output queue, from which
// it can leave on the m_ stream. The grid size is recomputed after reset and
// after every register write by a bit-serial divider, holding s_tready low.
// Reset clears all counters and the running row sum; the row store needs no
// clearing pass because row 0 ignores what it reads.
// A four-word output queue holds results while the receiver stalls; s_tready
// drops once queued and in-flight words would fill it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module subsampled_integral_image_unit import ssii_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // flow_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_TDATA_W-1:0]              m_tdata,   // integral_sum, grid_column, grid_row
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_AW-1:0]                   paddr,
    input  logic [APB_DW-1:0]                   pwdata,
    output logic [APB_DW-1:0]                   prdata,
    output logic                                pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] width_reg, height_reg, rate_reg;
    logic [CFG_W-1:0] cfg_width, cfg_height, cfg_rate, grid_width, grid_height;
    logic             cfg_wr, div_busy;

    logic             s_acc;
    logic [COL_W-1:0] col_addr;
    ctrl_info_t       info;
    logic [ACC_W-1:0] sample_ext, rs_new;
    logic [ACC_W-1:0] rsum_reg, rsum_next;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [ACC_W-1:0] s1_rs_reg;
    ctrl_info_t       s1_info_reg;
    logic [ACC_W-1:0] ram_rdata, above, sum;

    logic             fwd_valid_reg;
    logic [COL_W-1:0] fwd_addr_reg;
    logic [ACC_W-1:0] fwd_data_reg;

    out_word_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               fifo_push, fifo_pop;
    out_word_t          push_word, head_word;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            rate_reg   <= RST_SUBSAMPLE_RATE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:    width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= pwdata[CFG_W-1:0];
                REG_SUBSAMPLE_RATE: rate_reg   <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:    prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT:   prdata = APB_DW'(height_reg);
            REG_SUBSAMPLE_RATE: prdata = APB_DW'(rate_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg_width  = clamp_cfg(width_reg, MAX_WIDTH);
    assign cfg_height = clamp_cfg(height_reg, MAX_HEIGHT);
    assign cfg_rate   = clamp_cfg(rate_reg, RATE_MAX);

    ssii_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_wr),
        .dividend_a (cfg_width),
        .dividend_b (cfg_height),
        .divisor    (cfg_rate),
        .busy       (div_busy),
        .quot_a     (grid_width),
        .quot_b     (grid_height)
    );

    ssii_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s_acc),
        .cfg_width   (cfg_width),
        .cfg_height  (cfg_height),
        .cfg_rate    (cfg_rate),
        .grid_width  (grid_width),
        .grid_height (grid_height),
        .col_addr    (col_addr),
        .info        (info)
    );

    assign s_tready = !div_busy
                      && ((count_reg + FIFO_CW'(s1_valid_reg && s1_info_reg.emit))
                          <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_acc    = s_tvalid && s_tready;

    always_comb
    begin
        sample_ext = {{(ACC_W-SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}}, s_tdata[SAMPLE_BITS-1:0]};
        rs_new     = rsum_reg + sample_ext;
        rsum_next  = info.end_row ? '0 : rs_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsum_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                rsum_reg <= rsum_next;
            end
            s1_valid_reg  <= s_acc;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_addr_reg <= col_addr;
            s1_rs_reg   <= rs_new;
            s1_info_reg <= info;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= sum;
    end

    ssii_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (sum),
        .raddr (col_addr),
        .rdata (ram_rdata)
    );

    // The word ahead may have written this column at the edge of our read.
    always_comb
    begin
        if (s1_info_reg.row_zero)
        begin
            above = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            above = fwd_data_reg;
        end
        else
        begin
            above = ram_rdata;
        end
        sum = s1_rs_reg + above;
    end

    always_comb
    begin
        push_word.last = s1_info_reg.last;
        push_word.row  = s1_info_reg.grid_row;
        push_word.col  = s1_info_reg.grid_col;
        push_word.sum  = sum;
        head_word      = fifo_mem[rd_ptr_reg];
        fifo_push      = s1_valid_reg && s1_info_reg.emit;
        fifo_pop       = m_tvalid && m_tready;
        count_next     = count_reg + FIFO_CW'(fifo_push) - FIFO_CW'(fifo_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fifo_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head_word.row, head_word.col, head_word.sum};
    assign m_tlast  = head_word.last;

    `SSII_NEVER(a_fifo_overflow, fifo_push && !fifo_pop && count_reg[FIFO_CW-1], "overflow")
    `SSII_NEVER(a_accept_while_dividing, s_acc && div_busy, "accepted while dividing")
    `SSII_ASSERT(a_row_sum_clear, s_acc && info.end_row |=> rsum_reg == '0, "row sum not cleared")

endmodule
